[hdl/owpfd_pkg.sv]
// Shared types, codes and sizes for the one-wire pulse frame decoder.
`timescale 1ns / 1ps
package owpfd_pkg;

	localparam int DATA_BITS    = 16;
	localparam int COMMAND_BITS = 48;
	localparam int CRC_BITS     = 8;

	localparam int LEN_W  = 24;
	localparam int THR_W  = 16;
	localparam int ACC_W  = 48;
	localparam int CNT_W  = 6;
	localparam int ADDR_W = 5;
	localparam int DATA_W = 32;

	localparam logic [2:0] REG_OVERDRIVE   = 3'd0;
	localparam logic [2:0] REG_RESET_MIN   = 3'd1;
	localparam logic [2:0] REG_RESET_SPEC  = 3'd2;
	localparam logic [2:0] REG_OVD_MIN     = 3'd3;
	localparam logic [2:0] REG_BIT_CHECK   = 3'd4;
	localparam logic [2:0] REG_BIT_SAMPLE  = 3'd5;
	localparam logic [2:0] REG_GLITCH_MIN  = 3'd6;
	localparam logic [2:0] REG_IDLE_GAP    = 3'd7;

	localparam logic [THR_W-1:0] RST_RESET_MIN  = 16'd960;
	localparam logic [THR_W-1:0] RST_RESET_SPEC = 16'd960;
	localparam logic [THR_W-1:0] RST_OVD_MIN    = 16'd96;
	localparam logic [THR_W-1:0] RST_BIT_CHECK  = 16'd4;
	localparam logic [THR_W-1:0] RST_BIT_SAMPLE = 16'd30;
	localparam logic [THR_W-1:0] RST_GLITCH_MIN = 16'd20;
	localparam logic [LEN_W-1:0] RST_IDLE_GAP   = 24'd2000;

	typedef enum logic [2:0] {
		EV_RESET   = 3'd0,
		EV_DATA    = 3'd1,
		EV_COMMAND = 3'd2,
		EV_CRC     = 3'd3,
		EV_INVALID = 3'd4,
		EV_START   = 3'd5
	} event_kind_t;

	typedef struct packed {
		logic [LEN_W-1:0] high_length;
		logic [LEN_W-1:0] low_length;
	} in_item_t;

	typedef struct packed {
		event_kind_t      event_kind;
		logic [ACC_W-1:0] field_value;
		logic             warning;
	} out_item_t;

	typedef struct packed {
		logic             overdrive_mode;
		logic [THR_W-1:0] reset_min_samples;
		logic [THR_W-1:0] reset_spec_samples;
		logic [THR_W-1:0] ovd_reset_min_samples;
		logic [THR_W-1:0] bit_check_samples;
		logic [THR_W-1:0] bit_sample_samples;
		logic [THR_W-1:0] glitch_min_samples;
		logic [LEN_W-1:0] idle_gap_samples;
	} cfg_t;

endpackage

[hdl/owpfd_regs.sv]
// Configuration register file with APB-style access.
`timescale 1ns / 1ps
module owpfd_regs
	import owpfd_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [ADDR_W-1:0] paddr,
	input  logic [DATA_W-1:0] pwdata,
	output logic [DATA_W-1:0] prdata,
	output cfg_t              cfg
);

	cfg_t       cfg_q;
	logic       wr_en;
	logic [2:0] idx;

	assign wr_en = psel & penable & pwrite;
	assign idx   = paddr[ADDR_W-1:2];
	assign cfg   = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.overdrive_mode        <= 1'b0;
			cfg_q.reset_min_samples     <= RST_RESET_MIN;
			cfg_q.reset_spec_samples    <= RST_RESET_SPEC;
			cfg_q.ovd_reset_min_samples <= RST_OVD_MIN;
			cfg_q.bit_check_samples     <= RST_BIT_CHECK;
			cfg_q.bit_sample_samples    <= RST_BIT_SAMPLE;
			cfg_q.glitch_min_samples    <= RST_GLITCH_MIN;
			cfg_q.idle_gap_samples      <= RST_IDLE_GAP;
		end else if (wr_en) begin
			case (idx)
				REG_OVERDRIVE:  cfg_q.overdrive_mode        <= pwdata[0];
				REG_RESET_MIN:  cfg_q.reset_min_samples     <= pwdata[THR_W-1:0];
				REG_RESET_SPEC: cfg_q.reset_spec_samples    <= pwdata[THR_W-1:0];
				REG_OVD_MIN:    cfg_q.ovd_reset_min_samples <= pwdata[THR_W-1:0];
				REG_BIT_CHECK:  cfg_q.bit_check_samples     <= pwdata[THR_W-1:0];
				REG_BIT_SAMPLE: cfg_q.bit_sample_samples    <= pwdata[THR_W-1:0];
				REG_GLITCH_MIN: cfg_q.glitch_min_samples    <= pwdata[THR_W-1:0];
				REG_IDLE_GAP:   cfg_q.idle_gap_samples      <= pwdata[LEN_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (idx)
			REG_OVERDRIVE:  prdata = {31'd0, cfg_q.overdrive_mode};
			REG_RESET_MIN:  prdata = {16'd0, cfg_q.reset_min_samples};
			REG_RESET_SPEC: prdata = {16'd0, cfg_q.reset_spec_samples};
			REG_OVD_MIN:    prdata = {16'd0, cfg_q.ovd_reset_min_samples};
			REG_BIT_CHECK:  prdata = {16'd0, cfg_q.bit_check_samples};
			REG_BIT_SAMPLE: prdata = {16'd0, cfg_q.bit_sample_samples};
			REG_GLITCH_MIN: prdata = {16'd0, cfg_q.glitch_min_samples};
			REG_IDLE_GAP:   prdata = {8'd0, cfg_q.idle_gap_samples};
			default:        prdata = '0;
		endcase
	end

endmodule

[hdl/owpfd_core.sv]
// Pulse classifier and field framer between an input register and a result register.
`timescale 1ns / 1ps
module owpfd_core
	import owpfd_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  cfg_t      cfg,
	input  logic      in_valid,
	output logic      in_ready,
	input  in_item_t  in_data,
	output logic      out_valid,
	input  logic      out_ready,
	output out_item_t out_data
);

	typedef enum logic [1:0] {
		PH_DATA,
		PH_COMMAND,
		PH_CRC
	} phase_t;

	localparam logic [CNT_W:0] DATA_NEED    = (CNT_W+1)'(DATA_BITS);
	localparam logic [CNT_W:0] COMMAND_NEED = (CNT_W+1)'(COMMAND_BITS);
	localparam logic [CNT_W:0] CRC_NEED     = (CNT_W+1)'(CRC_BITS);

	in_item_t         item_s1;
	logic             valid_s1;
	logic             active_q;
	phase_t           phase_q;
	logic [CNT_W-1:0] count_q;
	logic [ACC_W-1:0] acc_q;
	logic             out_valid_q;
	out_item_t        out_data_q;

	logic             slot_free;
	logic             advance;
	logic             glitch;
	logic [THR_W-1:0] limit;
	logic             is_reset;
	logic             is_start;
	logic             warn;
	logic             bit_ok;
	logic             bit_one;
	logic [CNT_W:0]   count_next;
	logic [CNT_W:0]   need;
	event_kind_t      field_kind;
	logic             field_done;
	logic [ACC_W-1:0] acc_base;
	logic [ACC_W-1:0] acc_set;
	logic             emit;
	out_item_t        result;

	assign slot_free = !out_valid_q || out_ready;
	assign advance   = valid_s1 && slot_free;
	assign in_ready  = !valid_s1 || slot_free;
	assign out_valid = out_valid_q;
	assign out_data  = out_data_q;

	always_comb begin
		glitch = (item_s1.high_length < {8'd0, cfg.glitch_min_samples})
			|| (item_s1.low_length < {8'd0, cfg.glitch_min_samples});
		limit = cfg.overdrive_mode ? cfg.ovd_reset_min_samples : cfg.reset_min_samples;
		is_reset = item_s1.low_length > {8'd0, limit};
		if (cfg.overdrive_mode)
			warn = (item_s1.low_length > {8'd0, cfg.reset_min_samples})
				&& (item_s1.low_length < {8'd0, cfg.reset_spec_samples});
		else
			warn = item_s1.low_length < {8'd0, cfg.reset_spec_samples};
		is_start = item_s1.high_length > cfg.idle_gap_samples;
		bit_ok   = item_s1.low_length > {8'd0, cfg.bit_check_samples};
		bit_one  = item_s1.low_length <= {8'd0, cfg.bit_sample_samples};

		count_next = {1'b0, count_q} + 1'b1;
		case (phase_q)
			PH_DATA: begin
				need       = DATA_NEED;
				field_kind = EV_DATA;
			end
			PH_COMMAND: begin
				need       = COMMAND_NEED;
				field_kind = EV_COMMAND;
			end
			default: begin
				need       = CRC_NEED;
				field_kind = EV_CRC;
			end
		endcase
		field_done = count_next >= need;

		acc_base = (count_q == '0) ? '0 : acc_q;
		for (int i = 0; i < ACC_W; i++)
			acc_set[i] = acc_base[i] | (bit_one && (count_q == CNT_W'(i)));

		result.field_value = '0;
		result.warning     = 1'b0;
		if (is_reset) begin
			emit              = 1'b1;
			result.event_kind = EV_RESET;
			result.warning    = warn;
		end else if (is_start) begin
			emit              = 1'b1;
			result.event_kind = EV_START;
		end else if (!bit_ok) begin
			emit              = active_q;
			result.event_kind = EV_INVALID;
		end else begin
			emit               = active_q && field_done;
			result.event_kind  = field_kind;
			result.field_value = acc_set;
		end
		if (glitch)
			emit = 1'b0;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			active_q    <= 1'b0;
			phase_q     <= PH_DATA;
			count_q     <= '0;
			acc_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (in_valid && in_ready)
				valid_s1 <= 1'b1;
			else if (advance)
				valid_s1 <= 1'b0;

			if (advance) begin
				out_valid_q <= emit;
				if (!glitch) begin
					if (is_reset || is_start) begin
						active_q <= 1'b1;
						phase_q  <= PH_DATA;
						count_q  <= '0;
						acc_q    <= '0;
					end else if (active_q && bit_ok) begin
						if (field_done) begin
							count_q <= '0;
							acc_q   <= '0;
							phase_q <= (phase_q == PH_DATA) ? PH_COMMAND : PH_CRC;
						end else begin
							count_q <= count_next[CNT_W-1:0];
							acc_q   <= acc_set;
						end
					end
				end
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready)
			item_s1 <= in_data;
		if (advance && emit)
			out_data_q <= result;
	end

endmodule

[hdl/one_wire_pulse_frame_decoder_top.sv]
// Top level of the one-wire pulse frame decoder.
// A request is held in the input register and passed on to the result register once that is free.
// Throughput: one request per cycle while results are not stalled; set by the single input and result register pair.
// A request that yields no result still passes through the input register.
// Reset: arst_n clears framing, handshake state and restores register defaults.
`timescale 1ns / 1ps
module one_wire_pulse_frame_decoder_top
	import owpfd_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [ADDR_W-1:0] paddr,
	input  logic [DATA_W-1:0] pwdata,
	output logic [DATA_W-1:0] prdata,
	output logic              pready,
	input  logic              in_valid,
	output logic              in_ready,
	input  in_item_t          in_data,
	output logic              out_valid,
	input  logic              out_ready,
	output out_item_t         out_data
);

	cfg_t cfg;

	assign pready = 1'b1;

	owpfd_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.cfg     (cfg)
	);

	owpfd_core u_core (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data)
	);

endmodule

[hdl/owpfd_chk.sv]
// Port-level checker for the one-wire pulse frame decoder, bound to the top level.
`timescale 1ns / 1ps
module owpfd_chk
	import owpfd_pkg::*;
(
	input logic      clk,
	input logic      arst_n,
	input logic      in_ready,
	input logic      out_valid,
	input logic      out_ready,
	input out_item_t out_data
);

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_data))
		else $error("result dropped or changed while stalled");

	a_in_stall: assert property (@(posedge clk) disable iff (!arst_n)
		!in_ready |-> out_valid && !out_ready)
		else $error("request refused without a stalled result");

	a_warn_reset_only: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_data.warning |-> out_data.event_kind == EV_RESET)
		else $error("warning on a non-reset event");

	a_zero_value: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (out_data.event_kind == EV_RESET || out_data.event_kind == EV_START
			|| out_data.event_kind == EV_INVALID) |-> out_data.field_value == '0)
		else $error("nonzero value on a non-field event");

	a_data_width: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_data.event_kind == EV_DATA |-> (out_data.field_value >> DATA_BITS) == '0)
		else $error("data field wider than its bit count");

endmodule

bind one_wire_pulse_frame_decoder_top owpfd_chk u_chk (.*);

[verif/tb_one_wire_pulse_frame_decoder_top.sv]
// Testbench for the one-wire pulse frame decoder: directed and random pulse traffic checked against a predictor.
`timescale 1ns / 1ps

import owpfd_pkg::*;

typedef enum logic [1:0] {
	PH_DATA    = 2'd0,
	PH_COMMAND = 2'd1,
	PH_CRC     = 2'd2
} frame_phase_t;

class pulse_decode_checker;
	cfg_t         cfg;
	logic         decoding_active;
	frame_phase_t frame_phase;
	logic [5:0]   bit_count;
	logic [47:0]  bit_accum;
	out_item_t    expected_events[$];
	int           error_count;

	function new();
		cfg.overdrive_mode        = 1'b0;
		cfg.reset_min_samples     = RST_RESET_MIN;
		cfg.reset_spec_samples    = RST_RESET_SPEC;
		cfg.ovd_reset_min_samples = RST_OVD_MIN;
		cfg.bit_check_samples     = RST_BIT_CHECK;
		cfg.bit_sample_samples    = RST_BIT_SAMPLE;
		cfg.glitch_min_samples    = RST_GLITCH_MIN;
		cfg.idle_gap_samples      = RST_IDLE_GAP;
		decoding_active = 1'b0;
		frame_phase     = PH_DATA;
		bit_count       = '0;
		bit_accum       = '0;
		error_count     = 0;
	endfunction

	function void set_register(logic [2:0] idx, logic [31:0] val);
		case (idx)
			REG_OVERDRIVE:  cfg.overdrive_mode        = val[0];
			REG_RESET_MIN:  cfg.reset_min_samples     = val[THR_W-1:0];
			REG_RESET_SPEC: cfg.reset_spec_samples    = val[THR_W-1:0];
			REG_OVD_MIN:    cfg.ovd_reset_min_samples = val[THR_W-1:0];
			REG_BIT_CHECK:  cfg.bit_check_samples     = val[THR_W-1:0];
			REG_BIT_SAMPLE: cfg.bit_sample_samples    = val[THR_W-1:0];
			REG_GLITCH_MIN: cfg.glitch_min_samples    = val[THR_W-1:0];
			REG_IDLE_GAP:   cfg.idle_gap_samples      = val[LEN_W-1:0];
			default: ;
		endcase
	endfunction

	function void push_event(event_kind_t kind, logic [47:0] value, logic warn);
		out_item_t ev;
		ev.event_kind  = kind;
		ev.field_value = value;
		ev.warning     = warn;
		expected_events.push_back(ev);
	endfunction

	function void restart_framing();
		decoding_active = 1'b1;
		frame_phase     = PH_DATA;
		bit_count       = '0;
		bit_accum       = '0;
	endfunction

	function void note_pulse(in_item_t req);
		logic [LEN_W-1:0] hi;
		logic [LEN_W-1:0] lo;
		logic [THR_W-1:0] limit;
		logic             warn;
		int unsigned      need;
		event_kind_t      kind;
		hi = req.high_length;
		lo = req.low_length;
		if (hi < cfg.glitch_min_samples || lo < cfg.glitch_min_samples)
			return;
		limit = cfg.overdrive_mode ? cfg.ovd_reset_min_samples : cfg.reset_min_samples;
		if (lo > limit) begin
			if (cfg.overdrive_mode)
				warn = (lo > cfg.reset_min_samples) && (lo < cfg.reset_spec_samples);
			else
				warn = lo < cfg.reset_spec_samples;
			restart_framing();
			push_event(EV_RESET, '0, warn);
			return;
		end
		if (hi > cfg.idle_gap_samples) begin
			restart_framing();
			push_event(EV_START, '0, 1'b0);
			return;
		end
		if (!decoding_active)
			return;
		if (lo <= cfg.bit_check_samples) begin
			push_event(EV_INVALID, '0, 1'b0);
			return;
		end
		if (bit_count == 0)
			bit_accum = '0;
		if (lo <= cfg.bit_sample_samples && bit_count < ACC_W)
			bit_accum[bit_count] = 1'b1;
		bit_count = bit_count + 6'd1;
		case (frame_phase)
			PH_DATA: begin
				need = DATA_BITS;
				kind = EV_DATA;
			end
			PH_COMMAND: begin
				need = COMMAND_BITS;
				kind = EV_COMMAND;
			end
			default: begin
				need = CRC_BITS;
				kind = EV_CRC;
			end
		endcase
		if (bit_count >= need) begin
			push_event(kind, bit_accum, 1'b0);
			bit_count   = '0;
			bit_accum   = '0;
			frame_phase = (frame_phase == PH_DATA) ? PH_COMMAND : PH_CRC;
		end
	endfunction

	task report_mismatch(string msg);
		$display("ERROR @%0t: %s", $realtime, msg);
		error_count++;
	endtask

	task check_event(out_item_t got);
		out_item_t want;
		if (expected_events.size() == 0) begin
			report_mismatch($sformatf("unexpected event kind %0d value %h",
				got.event_kind, got.field_value));
			return;
		end
		want = expected_events.pop_front();
		if (got.event_kind !== want.event_kind)
			report_mismatch($sformatf("event_kind %0d, expected %0d",
				got.event_kind, want.event_kind));
		if (got.field_value !== want.field_value)
			report_mismatch($sformatf("field_value %h, expected %h",
				got.field_value, want.field_value));
		if (got.warning !== want.warning)
			report_mismatch($sformatf("warning %b, expected %b", got.warning, want.warning));
	endtask
endclass

module tb_one_wire_pulse_frame_decoder_top;

	localparam int CLK_PERIOD    = 12;
	localparam int RESET_CYCLES  = 12;
	localparam int RANDOM_ITEMS  = 1250;
	localparam int SETTLE_CYCLES = 4;
	localparam int CYCLE_LIMIT   = 600000;
	localparam int MAX_IDLE      = 12;

	localparam int SET_TIGHT     = 0;
	localparam int SET_TIGHT_OVD = 1;
	localparam int SET_ORDERED   = 2;
	localparam int SET_ZERO      = 3;
	localparam int SET_MAX       = 4;
	localparam int SET_RANDOM    = 5;
	localparam int SET_DEFAULT   = 6;
	localparam int SET_COUNT     = 7;

	logic              clk;
	logic              arst_n;
	logic              psel;
	logic              penable;
	logic              pwrite;
	logic [ADDR_W-1:0] paddr;
	logic [DATA_W-1:0] pwdata;
	logic [DATA_W-1:0] prdata;
	logic              pready;
	logic              in_valid;
	logic              in_ready;
	in_item_t          in_data;
	logic              out_valid;
	logic              out_ready;
	out_item_t         out_data;

	pulse_decode_checker decode_check;
	int unsigned         pulses_sent;
	int unsigned         events_seen = 0;
	int unsigned         cycle_count = 0;
	bit                  tx_idle_on;
	bit                  rx_idle_on = 1'b1;

	one_wire_pulse_frame_decoder_top u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.psel      (psel),
		.penable   (penable),
		.pwrite    (pwrite),
		.paddr     (paddr),
		.pwdata    (pwdata),
		.prdata    (prdata),
		.pready    (pready),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data)
	);

	initial begin
		clk = 1'b0;
		forever #(CLK_PERIOD / 2) clk = ~clk;
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("Simulation FAILED");
			$finish;
		end
	end

	function automatic int unsigned pick(int unsigned lo, int unsigned hi);
		return (hi > lo) ? $urandom_range(hi, lo) : lo;
	endfunction

	function automatic int unsigned max_of(int unsigned a, int unsigned b);
		return (a > b) ? a : b;
	endfunction

	function automatic int unsigned reset_limit();
		return decode_check.cfg.overdrive_mode ? decode_check.cfg.ovd_reset_min_samples
			: decode_check.cfg.reset_min_samples;
	endfunction

	function automatic logic [LEN_W-1:0] rand_len();
		logic [31:0] r;
		r = $urandom;
		return r[LEN_W-1:0];
	endfunction

	function automatic logic [LEN_W-1:0] glitch_len();
		int unsigned g;
		g = decode_check.cfg.glitch_min_samples;
		return (g == 0) ? '0 : LEN_W'(pick(0, g - 1));
	endfunction

	function automatic logic [LEN_W-1:0] high_bit();
		int unsigned g;
		g = decode_check.cfg.glitch_min_samples;
		if ($urandom_range(3, 0) == 0)
			return LEN_W'(pick(g, decode_check.cfg.idle_gap_samples));
		return LEN_W'(pick(g, g + 60));
	endfunction

	function automatic logic [LEN_W-1:0] gap_high();
		int unsigned idle;
		idle = decode_check.cfg.idle_gap_samples;
		if ($urandom_range(1, 0))
			return LEN_W'(pick(idle + 1, idle + 200));
		return LEN_W'(pick(idle + 1, 24'hFFFFFF));
	endfunction

	function automatic logic [LEN_W-1:0] bit_low();
		int unsigned g;
		int unsigned chk;
		int unsigned smp;
		g   = decode_check.cfg.glitch_min_samples;
		chk = decode_check.cfg.bit_check_samples;
		smp = decode_check.cfg.bit_sample_samples;
		if ($urandom_range(1, 0))
			return LEN_W'(pick(max_of(chk + 1, g), smp));
		return LEN_W'(pick(max_of(smp + 1, g), reset_limit()));
	endfunction

	function automatic logic [LEN_W-1:0] invalid_low();
		return LEN_W'(pick(decode_check.cfg.glitch_min_samples,
			decode_check.cfg.bit_check_samples));
	endfunction

	function automatic logic [LEN_W-1:0] reset_low();
		int unsigned lim;
		int unsigned spec;
		lim  = reset_limit();
		spec = decode_check.cfg.reset_spec_samples;
		case ($urandom_range(3, 0))
			0: return LEN_W'(pick(lim + 1, 24'hFFFFFF));
			1: return LEN_W'(pick(decode_check.cfg.reset_min_samples + 1, spec + 8));
			default: return LEN_W'(pick(lim + 1, max_of(spec, lim) + 40));
		endcase
	endfunction

	function automatic cfg_t make_settings(int kind);
		cfg_t         c;
		logic [127:0] rnd;
		c = '0;
		case (kind)
			SET_TIGHT, SET_TIGHT_OVD: begin
				c.overdrive_mode        = (kind == SET_TIGHT_OVD);
				c.reset_min_samples     = 16'd500;
				c.reset_spec_samples    = 16'd700;
				c.ovd_reset_min_samples = 16'd200;
				c.bit_check_samples     = 16'd10;
				c.bit_sample_samples    = 16'd40;
				c.glitch_min_samples    = 16'd5;
				c.idle_gap_samples      = 24'd1000;
			end
			SET_ORDERED: begin
				c.overdrive_mode        = ($urandom_range(1, 0) != 0);
				c.glitch_min_samples    = THR_W'($urandom_range(30, 1));
				c.bit_check_samples     = THR_W'(c.glitch_min_samples + $urandom_range(20, 0));
				c.bit_sample_samples    = THR_W'(c.bit_check_samples + $urandom_range(60, 1));
				c.ovd_reset_min_samples =
					THR_W'(c.bit_sample_samples + $urandom_range(200, 1));
				c.reset_min_samples     =
					THR_W'(c.ovd_reset_min_samples + $urandom_range(600, 0));
				c.reset_spec_samples    =
					THR_W'(c.reset_min_samples + $urandom_range(400, 0));
				c.idle_gap_samples      =
					LEN_W'($urandom_range(5000, c.bit_sample_samples + 1));
			end
			SET_ZERO: c = '0;
			SET_MAX: c = '1;
			SET_RANDOM: begin
				rnd = {$urandom, $urandom, $urandom, $urandom};
				c = rnd[$bits(cfg_t)-1:0];
			end
			default: begin
				c.overdrive_mode        = 1'b0;
				c.reset_min_samples     = RST_RESET_MIN;
				c.reset_spec_samples    = RST_RESET_SPEC;
				c.ovd_reset_min_samples = RST_OVD_MIN;
				c.bit_check_samples     = RST_BIT_CHECK;
				c.bit_sample_samples    = RST_BIT_SAMPLE;
				c.glitch_min_samples    = RST_GLITCH_MIN;
				c.idle_gap_samples      = RST_IDLE_GAP;
			end
		endcase
		return c;
	endfunction

	task automatic write_reg(logic [2:0] idx, logic [31:0] val, bit last);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= {idx, 2'b00};
		pwdata  <= val;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		decode_check.set_register(idx, val);
		if (last) begin
			psel    <= 1'b0;
			penable <= 1'b0;
			pwrite  <= 1'b0;
		end
	endtask

	task automatic apply_settings(cfg_t c);
		logic [31:0] noise;
		noise = $urandom;
		write_reg(REG_OVERDRIVE, {noise[31:1], c.overdrive_mode}, 1'b0);
		write_reg(REG_RESET_MIN, {noise[31:16], c.reset_min_samples}, 1'b0);
		write_reg(REG_RESET_SPEC, {noise[15:0], c.reset_spec_samples}, 1'b0);
		write_reg(REG_OVD_MIN, {noise[31:16], c.ovd_reset_min_samples}, 1'b0);
		write_reg(REG_BIT_CHECK, {noise[15:0], c.bit_check_samples}, 1'b0);
		write_reg(REG_BIT_SAMPLE, {noise[31:16], c.bit_sample_samples}, 1'b0);
		write_reg(REG_GLITCH_MIN, {noise[15:0], c.glitch_min_samples}, 1'b0);
		write_reg(REG_IDLE_GAP, {noise[31:24], c.idle_gap_samples}, 1'b1);
	endtask

	task automatic settle();
		in_valid <= 1'b0;
		while (decode_check.expected_events.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic send_pulse(logic [LEN_W-1:0] hi, logic [LEN_W-1:0] lo);
		in_item_t    req;
		int unsigned gap;
		req.high_length = hi;
		req.low_length  = lo;
		gap = tx_idle_on ? $urandom_range(MAX_IDLE, 0) : 0;
		if (gap != 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		in_data  <= req;
		do @(posedge clk); while (!in_ready);
		if (hi >= decode_check.cfg.glitch_min_samples && lo >= decode_check.cfg.glitch_min_samples)
			pulses_sent++;
		decode_check.note_pulse(req);
	endtask

	task automatic send_frame();
		int unsigned nbits;
		int unsigned choice;
		if ($urandom_range(1, 0))
			send_pulse(high_bit(), reset_low());
		else
			send_pulse(gap_high(), bit_low());
		nbits = DATA_BITS + COMMAND_BITS + CRC_BITS * $urandom_range(4, 0);
		if ($urandom_range(5, 0) == 0)
			nbits = $urandom_range(nbits, 1);
		for (int i = 0; i < nbits; i++) begin
			choice = $urandom_range(39, 0);
			case (choice)
				0: send_pulse(glitch_len(), bit_low());
				1: send_pulse(high_bit(), glitch_len());
				2: send_pulse(high_bit(), invalid_low());
				3: send_pulse(rand_len(), rand_len());
				default: ;
			endcase
			send_pulse(high_bit(), bit_low());
		end
	endtask

	task automatic send_noise();
		int unsigned n;
		n = $urandom_range(4, 1);
		repeat (n) begin
			if ($urandom_range(1, 0))
				send_pulse(rand_len(), rand_len());
			else
				send_pulse(LEN_W'($urandom_range(80, 0)), LEN_W'($urandom_range(80, 0)));
		end
	endtask

	initial begin
		out_item_t ev;
		forever begin
			@(posedge clk);
			if (arst_n)
				break;
		end
		forever begin
			int unsigned stall;
			stall = rx_idle_on ? $urandom_range(MAX_IDLE, 0) : 0;
			if (stall != 0) begin
				out_ready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			out_ready <= 1'b1;
			do @(posedge clk); while (!out_valid);
			ev = out_data;
			decode_check.check_event(ev);
			events_seen++;
			if (events_seen % 40 == 0)
				rx_idle_on = ($urandom_range(2, 0) != 0);
		end
	end

	initial begin
		int unsigned phase;
		int unsigned kind;
		int unsigned budget;
		int unsigned target;
		int unsigned random_start;
		decode_check = new();
		pulses_sent  = 0;
		tx_idle_on   = 1'b1;
		arst_n    <= 1'b0;
		psel      <= 1'b0;
		penable   <= 1'b0;
		pwrite    <= 1'b0;
		paddr     <= '0;
		pwdata    <= '0;
		in_valid  <= 1'b0;
		in_data   <= '0;
		out_ready <= 1'b0;
		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		send_pulse(24'd0, 24'd0);
		send_pulse(24'd19, 24'd500);
		send_pulse(24'd500, 24'd19);
		send_pulse(24'd500, 24'd25);
		send_pulse(24'hFFFFFF, 24'd25);
		send_pulse(24'd20, 24'd20);
		send_pulse(24'd2000, 24'd30);
		send_pulse(24'd2000, 24'd31);
		send_pulse(24'd500, 24'd960);
		send_pulse(24'd500, 24'd961);
		send_pulse(24'hFFFFFF, 24'hFFFFFF);
		settle();
		apply_settings(make_settings(SET_TIGHT));
		send_pulse(24'd50, 24'd600);
		send_pulse(24'd50, 24'd5);
		send_pulse(24'd50, 24'd10);
		send_pulse(24'd50, 24'd11);
		send_pulse(24'd1001, 24'd40);
		send_pulse(24'd50, 24'd700);
		settle();
		write_reg(REG_OVERDRIVE, 32'd1, 1'b1);
		send_pulse(24'd50, 24'd201);
		send_pulse(24'd50, 24'd600);
		send_pulse(24'd50, 24'd700);
		send_pulse(24'd50, 24'd200);
		send_pulse(24'd1000, 24'd41);

		random_start = pulses_sent;
		phase = 0;
		while (pulses_sent - random_start < RANDOM_ITEMS) begin
			kind = phase % SET_COUNT;
			settle();
			apply_settings(make_settings(kind));
			budget = (kind == SET_ZERO || kind == SET_MAX || kind == SET_RANDOM) ? 40 : 160;
			target = pulses_sent + budget;
			while (pulses_sent < target && pulses_sent - random_start < RANDOM_ITEMS) begin
				tx_idle_on = ($urandom_range(3, 0) != 0);
				if ($urandom_range(7, 0) == 0)
					send_noise();
				else
					send_frame();
			end
			phase++;
		end
		settle();

		if (decode_check.error_count == 0 && decode_check.expected_events.size() == 0) begin
			$display("Simulation PASSED");
		end else begin
			$display("Simulation FAILED");
		end
		$finish;
	end

endmodule
